/* design/round_brush_stroke_painter_unit_assert.svh */
// Assertion macros for the stroke painter.
`ifndef ROUND_BRUSH_STROKE_PAINTER_UNIT_ASSERT_SVH
`define ROUND_BRUSH_STROKE_PAINTER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RBSP_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define RBSP_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RBSP_ASSERT_IMP(label, clk, rst, a, c)
`define RBSP_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

/* design/rbsp_pkg.sv */
// Package: types, constants and state codes of the stroke painter.
package rbsp_pkg;
  localparam int CanvasWidth  = 1080;
  localparam int CanvasHeight = 1920;
  localparam int BrushRadius  = 6;
  localparam int StrokeStep   = 4;
  localparam int AreaMargin   = BrushRadius + 2;
  localparam int PixCount     = CanvasWidth * CanvasHeight;
  localparam int AddrW        = $clog2(PixCount);
  localparam logic [15:0] White = 16'hFFFF;

  localparam logic [1:0] KindPress = 2'd0;
  localparam logic [1:0] KindDrag  = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;
  localparam logic [1:0] KindRead  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] touch_x;
    logic [10:0] touch_y;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] area_left;
    logic signed [11:0] area_top;
    logic signed [11:0] area_right;
    logic signed [11:0] area_bottom;
    logic [15:0]        pixel_value;
  } out_item_t;

  // memory request between sequencer and frame store
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [AddrW-1:0] addr;
    logic [15:0]      data;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_DIV_START, ST_DIV, ST_DISC,
    ST_READ, ST_READ_WAIT, ST_OUT
  } state_t;
endpackage

/* design/rbsp_frame_store.sv */
// Frame store: single-port synchronous pixel memory, registered read.
module rbsp_frame_store import rbsp_pkg::*; (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);
  logic [15:0] mem [PixCount];

  // write or read one pixel per cycle
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.data;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end
endmodule

/* design/rbsp_divider.sv */
// Divider: restoring unsigned division, one quotient bit per cycle.
module rbsp_divider import rbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [21:0] num,
  input  logic [10:0] den,
  output logic        busy,
  output logic [21:0] quo
);
  logic [4:0]  cnt;
  logic [21:0] q;
  logic [11:0] rem;
  logic [11:0] trial;

  assign trial = {rem[10:0], q[21]};
  assign quo   = q;

  // shift in one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd22;
      q    <= num;
      rem  <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q   <= {q[20:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[20:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* design/round_brush_stroke_painter_unit.sv */
// Top level: stroke sequencer driving the frame store and divider.
//
// Usage: items come in on in_valid/in_stall with payload in_item; one result
// per item leaves on out_valid/out_stall with payload out_item. The brush
// color is written through cfg_valid/cfg_ready/cfg_data; the user must do so
// only while idle, which the block itself does not enforce. After reset the
// block sweeps the frame store to white, one pixel a cycle, and takes no
// item until that is done. A read addresses the store, waits for the
// registered read data and then sends its result. A clear sweeps the store
// to white as after reset. A press or drag runs, per stamped disc, two
// divisions, one per axis, and a scan of the brush square; a stroke of S
// steps stamps S/4+1 discs, S/4 rounded down. The single frame store port
// sets the pace of sweeps and scans. One item is in work at a time. A
// stalled result stays in the output register while the next item is taken
// and worked on; that item then waits in its last step until the output register is free.
`include "round_brush_stroke_painter_unit_assert.svh"
module round_brush_stroke_painter_unit import rbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  state_t state, state_next;
  logic [15:0] brush_color;
  logic [10:0] last_x, last_y;
  in_item_t    cur;
  logic [AddrW-1:0] sweep;
  logic signed [12:0] x0, y0, dx, dy;
  logic [10:0] steps;
  logic [11:0] i_cnt;
  logic        axis;
  logic signed [12:0] cx, cy;
  logic signed [4:0]  ox, oy;
  mem_req_t    req;
  logic [15:0] rdata;
  logic        div_start, div_busy;
  logic [21:0] div_num, div_quo;
  logic [10:0] adx, ady;
  logic signed [13:0] px, py;
  logic [9:0]  r2;
  logic        pix_ok;
  logic [21:0] prod;
  logic signed [13:0] lft, tp, rgt, bot;
  out_item_t   out_item_next;
  logic        out_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  rbsp_frame_store u_store (.clk(clk), .req(req), .rdata(rdata));
  rbsp_divider u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(steps), .busy(div_busy), .quo(div_quo));

  function automatic logic signed [11:0] sat12(input logic signed [13:0] v);
    if (v < -14'sd2048) return -12'sd2048;
    if (v > 14'sd2047) return 12'sd2047;
    return v[11:0];
  endfunction

  // absolute deltas, division dividend and brush pixel test
  assign adx   = dx[12] ? 11'(-dx) : dx[10:0];
  assign ady   = dy[12] ? 11'(-dy) : dy[10:0];
  assign prod  = 22'(i_cnt) * 22'(axis ? ady : adx);
  assign div_num = prod;
  assign px    = 14'(cx) + 14'(ox);
  assign py    = 14'(cy) + 14'(oy);
  assign r2    = 10'(ox) * 10'(ox) + 10'(oy) * 10'(oy);
  assign pix_ok = (r2 <= 10'(BrushRadius * BrushRadius)) && !px[13] && !py[13]
    && (px < 14'(CanvasWidth)) && (py < 14'(CanvasHeight));

  // next state and memory requests
  always_comb begin
    state_next = state;
    req = '0;
    div_start = 1'b0;
    case (state)
      ST_INIT, ST_CLEAR: begin
        req.wr = 1'b1;
        req.addr = sweep;
        req.data = White;
        if (sweep == AddrW'(PixCount - 1)) state_next = (state == ST_INIT) ? ST_IDLE : ST_OUT;
      end
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          case (in_item.kind)
            KindClear: state_next = ST_CLEAR;
            KindRead:  state_next = ST_READ;
            default:   state_next = ST_DIV_START;
          endcase
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && !div_start) state_next = axis ? ST_DISC : ST_DIV_START;
      end
      ST_DISC: begin
        req.wr = pix_ok;
        req.addr = AddrW'(py[10:0] * AddrW'(CanvasWidth)) + AddrW'(px[10:0]);
        req.data = brush_color;
        if (ox == 5'(BrushRadius) && oy == 5'(BrushRadius)) begin
          state_next = (12'(i_cnt + 12'(StrokeStep)) > 12'(steps)) ? ST_OUT : ST_DIV_START;
        end
      end
      ST_READ: begin
        req.rd = 1'b1;
        req.addr = AddrW'(cur.touch_y * AddrW'(CanvasWidth)) + AddrW'(cur.touch_x);
        state_next = ST_READ_WAIT;
      end
      ST_READ_WAIT: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // assemble the result of the item in work
  always_comb begin
    out_item_next = '0;
    if (cur.kind == KindClear) begin
      out_item_next.area_right  = 12'(CanvasWidth - 1);
      out_item_next.area_bottom = 12'(CanvasHeight - 1);
    end else if (cur.kind == KindRead) begin
      if (cur.touch_x < 11'(CanvasWidth) && cur.touch_y < 11'(CanvasHeight))
        out_item_next.pixel_value = rdata;
    end else begin
      out_item_next.area_left   = sat12(lft);
      out_item_next.area_top    = sat12(tp);
      out_item_next.area_right  = sat12(rgt);
      out_item_next.area_bottom = sat12(bot);
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      brush_color <= '0;
      last_x <= '0;
      last_y <= '0;
      out_valid <= 1'b0;
      axis <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) brush_color <= cfg_data;
      // load a new result when the register is free, drop one that transfers
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
        out_item <= out_item_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT, ST_CLEAR: begin
          sweep <= (sweep == AddrW'(PixCount - 1)) ? '0 : sweep + AddrW'(1);
        end
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cur <= in_item;
            axis <= 1'b0;
            i_cnt <= '0;
            x0 <= (in_item.kind == KindPress) ? 13'(in_item.touch_x) : 13'(last_x);
            y0 <= (in_item.kind == KindPress) ? 13'(in_item.touch_y) : 13'(last_y);
            dx <= 13'(in_item.touch_x) - ((in_item.kind == KindPress) ?
                  13'(in_item.touch_x) : 13'(last_x));
            dy <= 13'(in_item.touch_y) - ((in_item.kind == KindPress) ?
                  13'(in_item.touch_y) : 13'(last_y));
          end
        end
        ST_DIV_START: begin
          steps <= (adx > ady) ? adx : ady;
          if (adx == 11'd0 && ady == 11'd0) steps <= 11'd1;
        end
        ST_DIV: begin
          if (!div_busy) begin
            if (!axis) cx <= x0 + (dx[12] ? -13'(div_quo) : 13'(div_quo));
            else       cy <= y0 + (dy[12] ? -13'(div_quo) : 13'(div_quo));
            axis <= !axis;
            ox <= -5'(BrushRadius);
            oy <= -5'(BrushRadius);
          end
        end
        ST_DISC: begin
          if (ox == 5'(BrushRadius)) begin
            ox <= -5'(BrushRadius);
            oy <= oy + 5'sd1;
          end else begin
            ox <= ox + 5'sd1;
          end
          if (ox == 5'(BrushRadius) && oy == 5'(BrushRadius)) begin
            i_cnt <= i_cnt + 12'(StrokeStep);
          end
        end
        ST_OUT: begin
          if (out_free && cur.kind != KindClear && cur.kind != KindRead) begin
            last_x <= cur.touch_x;
            last_y <= cur.touch_y;
          end
        end
        default: ;
      endcase
    end
  end

  assign lft = 14'((x0 < x0 + dx) ? x0 : x0 + dx) - 14'(AreaMargin);
  assign tp  = 14'((y0 < y0 + dy) ? y0 : y0 + dy) - 14'(AreaMargin);
  assign rgt = 14'((x0 > x0 + dx) ? x0 : x0 + dx) + 14'(AreaMargin);
  assign bot = 14'((y0 > y0 + dy) ? y0 : y0 + dy) + 14'(AreaMargin);

  `RBSP_ASSERT_IMP(a_no_take_busy, clk, rst, in_valid && !in_stall, state == ST_IDLE)
  `RBSP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `RBSP_ASSERT_IMP(a_wr_not_rd, clk, rst, req.wr, !req.rd)
endmodule

/* dv/round_brush_stroke_painter_unit_test.sv */
// Testbench for the round brush stroke painter: directed and random touch events.
module round_brush_stroke_painter_unit_test import rbsp_pkg::*; ();

  localparam int CycleLimit = 20000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // painter state mirrored by the predictor
  logic [15:0] paint_color = '0;
  logic [10:0] prev_x = '0;
  logic [10:0] prev_y = '0;
  bit [15:0]   painted_px [int];

  in_item_t  touch_q [$];
  out_item_t result_q [$];
  int        err_count = 0;
  int        taken_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  logic      hold_off = 1'b0;

  round_brush_stroke_painter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [11:0] clamp12(input int v);
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v[11:0];
  endfunction

  function automatic int clip11(input int v);
    return (v < 0) ? 0 : ((v > 2047) ? 2047 : v);
  endfunction

  function automatic void stamp_brush(input int cx, input int cy);
    int px;
    int py;
    for (int oy = -BrushRadius; oy <= BrushRadius; oy++) begin
      for (int ox = -BrushRadius; ox <= BrushRadius; ox++) begin
        px = cx + ox;
        py = cy + oy;
        if (ox * ox + oy * oy <= BrushRadius * BrushRadius &&
            px >= 0 && px < CanvasWidth && py >= 0 && py < CanvasHeight)
          painted_px[py * CanvasWidth + px] = paint_color;
      end
    end
  endfunction

  function automatic void paint_stroke(input int x0, input int y0, input int x1, input int y1);
    int dx;
    int dy;
    int steps;
    dx = x1 - x0;
    dy = y1 - y0;
    steps = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ?
            ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
    if (steps == 0) begin
      stamp_brush(x1, y1);
      return;
    end
    // SV integer division truncates toward zero
    for (int i = 0; i <= steps; i += StrokeStep)
      stamp_brush(x0 + dx * i / steps, y0 + dy * i / steps);
  endfunction

  function automatic out_item_t paint_event(input in_item_t ev);
    out_item_t r;
    int x0;
    int y0;
    int x1;
    int y1;
    int idx;
    r = '0;
    case (ev.kind)
      KindPress, KindDrag: begin
        if (ev.kind == KindPress) begin
          prev_x = ev.touch_x;
          prev_y = ev.touch_y;
        end
        x0 = prev_x;
        y0 = prev_y;
        x1 = ev.touch_x;
        y1 = ev.touch_y;
        paint_stroke(x0, y0, x1, y1);
        r.area_left   = clamp12(((x0 < x1) ? x0 : x1) - AreaMargin);
        r.area_top    = clamp12(((y0 < y1) ? y0 : y1) - AreaMargin);
        r.area_right  = clamp12(((x0 > x1) ? x0 : x1) + AreaMargin);
        r.area_bottom = clamp12(((y0 > y1) ? y0 : y1) + AreaMargin);
        prev_x = ev.touch_x;
        prev_y = ev.touch_y;
      end
      KindClear: begin
        painted_px.delete();
        r.area_right  = clamp12(CanvasWidth - 1);
        r.area_bottom = clamp12(CanvasHeight - 1);
      end
      default: begin
        if (ev.touch_x < CanvasWidth && ev.touch_y < CanvasHeight) begin
          idx = ev.touch_y * CanvasWidth + ev.touch_x;
          r.pixel_value = painted_px.exists(idx) ? painted_px[idx] : White;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Driver: feed touch events with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(paint_event(in_item));
        taken_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (touch_q.size() != 0) begin
          in_item <= touch_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= no_idle ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and draw the next stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          want = result_q.pop_front();
          if (out_item.area_left != want.area_left)
            report_mismatch("area_left", out_item.area_left, want.area_left);
          if (out_item.area_top != want.area_top)
            report_mismatch("area_top", out_item.area_top, want.area_top);
          if (out_item.area_right != want.area_right)
            report_mismatch("area_right", out_item.area_right, want.area_right);
          if (out_item.area_bottom != want.area_bottom)
            report_mismatch("area_bottom", out_item.area_bottom, want.area_bottom);
          if (out_item.pixel_value != want.pixel_value)
            report_mismatch("pixel_value", out_item.pixel_value, want.pixel_value);
        end
        stall_left <= no_idle ? 0 : $urandom_range(0, 11);
        out_stall <= hold_off;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  // Hold the receiver off for a long stretch once traffic is flowing
  initial begin
    wait (taken_count >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("round_brush_stroke_painter_unit_test: errors");
      $finish;
    end
  end

  // sample on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (touch_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_brush(input logic [15:0] c);
    wait_idle();
    cfg_data <= c;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    paint_color = c;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_touch(input logic [1:0] k, input int x, input int y);
    in_item_t ev;
    ev.kind = k;
    ev.touch_x = 11'(clip11(x));
    ev.touch_y = 11'(clip11(y));
    touch_q.push_back(ev);
  endtask

  // Random phase: mostly press-drag-read gestures, some noise
  task automatic add_gestures(input int count);
    int n;
    int cx;
    int cy;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        add_touch($urandom_range(0, 2) == 0 ? KindRead : 2'($urandom_range(0, 1)),
                  $urandom_range(0, 2047), $urandom_range(0, 2047));
        n++;
      end else begin
        cx = $urandom_range(0, CanvasWidth - 1);
        cy = $urandom_range(0, CanvasHeight - 1);
        add_touch(KindPress, cx, cy);
        n++;
        repeat ($urandom_range(1, 4)) begin
          cx = clip11(cx + $urandom_range(0, 120) - 60);
          cy = clip11(cy + $urandom_range(0, 120) - 60);
          add_touch(KindDrag, cx, cy);
          n++;
        end
        repeat ($urandom_range(1, 3)) begin
          add_touch(KindRead, cx + $urandom_range(0, 16) - 8, cy + $urandom_range(0, 16) - 8);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners, off-canvas points, saturation, clear
    set_brush(16'hF800);
    add_touch(KindRead, 0, 0);
    add_touch(KindPress, 0, 0);
    add_touch(KindRead, 0, 0);
    add_touch(KindRead, 6, 0);
    add_touch(KindRead, 7, 0);
    add_touch(KindPress, 1079, 1919);
    add_touch(KindRead, 1079, 1919);
    add_touch(KindRead, 1080, 0);
    add_touch(KindRead, 2047, 2047);
    add_touch(KindDrag, 2047, 2047);
    add_touch(KindPress, 3, 5);
    add_touch(KindDrag, 3, 5);
    add_touch(KindDrag, 40, 5);
    add_touch(KindDrag, 40, 60);
    add_touch(KindRead, 20, 5);
    add_touch(KindRead, 38, 60);
    add_touch(KindClear, 0, 0);
    add_touch(KindRead, 3, 5);
    add_touch(KindPress, 500, 500);
    add_touch(KindRead, 500, 500);

    // Random phases at several brush colors, extremes included
    set_brush(16'hFFFF);
    no_idle = 1'b0;
    add_gestures(20);
    set_brush(16'h0000);
    no_idle = 1'b1;
    add_gestures(20);
    set_brush(16'($urandom_range(0, 65535)));
    no_idle = 1'b0;
    add_gestures(20);
    set_brush(16'($urandom_range(0, 65535)));
    no_idle = ($urandom_range(0, 1) == 0);
    add_gestures(20);

    wait_idle();
    repeat (50) @(posedge clk);
    if (err_count == 0)
      $display("round_brush_stroke_painter_unit_test: clean");
    else
      $display("round_brush_stroke_painter_unit_test: errors");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/rbsp_pkg.sv
design/rbsp_frame_store.sv
design/rbsp_divider.sv
design/round_brush_stroke_painter_unit.sv
dv/round_brush_stroke_painter_unit_test.sv
